// ----- src/tdoc_pkg.sv -----
// ----------------------------------------------------------------------------
// tdoc_pkg
// Shared types and constants for the two-door occupancy counter.
// ----------------------------------------------------------------------------
`default_nettype none

package tdoc_pkg;

    // Configuration register width and defaults
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam int COUNT_BITS_DEF = 16;
    localparam int TIMER_BITS_DEF = 16;

    localparam logic [CFG_W-1:0] SEQ_TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_W-1:0] HB_HALF_RST     = 16'd125;
    localparam logic [CFG_W-1:0] PULSE_LEN_RST   = 16'd60;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd15;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HB_HALF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd3;

    // Door sequence states
    typedef enum logic [1:0] {
        DOOR_FREE      = 2'd0,
        DOOR_MAYBE_IN  = 2'd1,
        DOOR_MAYBE_OUT = 2'd2,
        DOOR_BLOCKED   = 2'd3
    } t_door_mode;

    // Confirmed events reported by one door lane
    typedef struct packed {
        logic entry;
        logic leave;
    } t_door_evt;

    // Configuration register set
    typedef struct packed {
        logic [CFG_W-1:0] seq_timeout;
        logic [CFG_W-1:0] hb_half;
        logic [CFG_W-1:0] pulse_len;
        logic [CFG_W-1:0] debounce;
    } t_cfg;

endpackage

`default_nettype wire

// ----- src/two_door_occupancy_counter.sv -----
// ----------------------------------------------------------------------------
// two_door_occupancy_counter
// People counter for two doors with an outer and an inner beam sensor each.
// ----------------------------------------------------------------------------
// Each input transaction is one sampled tick of the four beam sensors and the
// clear button. The tick is processed combinationally: two door lanes run
// their entry/exit machines side by side, and a merge stage applies their
// events to the count in door order and updates the heartbeat, the lamp
// pulses and the debounced clear. The result is written to an output register
// when the tick is accepted, and a new tick is taken every clock as long as
// that register is empty or draining, so throughput is one tick per cycle.
// Configuration writes take effect on the next tick and must only be issued
// while no result is pending.
`default_nettype none

module two_door_occupancy_counter #(
    parameter int COUNT_BITS = tdoc_pkg::COUNT_BITS_DEF,
    parameter int TIMER_BITS = tdoc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [tdoc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tdoc_pkg::CFG_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_door1_outer,
    input  wire logic                           i_door1_inner,
    input  wire logic                           i_door2_outer,
    input  wire logic                           i_door2_inner,
    input  wire logic                           i_clear_button,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [15:0]                         o_people_count,
    output logic                                o_occupied_lamp,
    output logic                                o_entry_lamp,
    output logic                                o_exit_lamp,
    output logic                                o_heartbeat_lamp,
    output logic [1:0]                          o_door1_phase,
    output logic [1:0]                          o_door2_phase
);

    tdoc_pkg::t_cfg        r_cfg;
    tdoc_pkg::t_door_evt   evt1, evt2;
    logic                  adv, clear;
    logic [1:0]            phase1, phase2;
    logic [COUNT_BITS-1:0] count;
    logic                  entry_lamp, exit_lamp, hb_lamp;

    logic                  r_out_valid;
    logic [15:0]           r_people_count;
    logic                  r_occupied, r_entry, r_exit, r_hb;
    logic [1:0]            r_phase1, r_phase2;

    // Accept while the output register is empty or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign adv        = i_in_valid && o_in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq_timeout <= tdoc_pkg::SEQ_TIMEOUT_RST;
            r_cfg.hb_half     <= tdoc_pkg::HB_HALF_RST;
            r_cfg.pulse_len   <= tdoc_pkg::PULSE_LEN_RST;
            r_cfg.debounce    <= tdoc_pkg::DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tdoc_pkg::REG_SEQ_TIMEOUT: r_cfg.seq_timeout <= i_cfg_data;
                tdoc_pkg::REG_HB_HALF:     r_cfg.hb_half     <= i_cfg_data;
                tdoc_pkg::REG_PULSE_LEN:   r_cfg.pulse_len   <= i_cfg_data;
                tdoc_pkg::REG_DEBOUNCE:    r_cfg.debounce    <= i_cfg_data;
                default:                   r_cfg             <= r_cfg;
            endcase
        end
    end

    // Door lanes
    tdoc_door_lane #(
        .TIMER_BITS (TIMER_BITS)
    ) u_door1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_clear   (clear),
        .i_outer   (i_door1_outer),
        .i_inner   (i_door1_inner),
        .i_timeout (r_cfg.seq_timeout),
        .o_evt     (evt1),
        .o_phase   (phase1)
    );

    tdoc_door_lane #(
        .TIMER_BITS (TIMER_BITS)
    ) u_door2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_clear   (clear),
        .i_outer   (i_door2_outer),
        .i_inner   (i_door2_inner),
        .i_timeout (r_cfg.seq_timeout),
        .o_evt     (evt2),
        .o_phase   (phase2)
    );

    // Merge stage
    tdoc_merge #(
        .COUNT_BITS (COUNT_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_cfg        (r_cfg),
        .i_button     (i_clear_button),
        .i_evt1       (evt1),
        .i_evt2       (evt2),
        .o_clear      (clear),
        .o_count      (count),
        .o_entry_lamp (entry_lamp),
        .o_exit_lamp  (exit_lamp),
        .o_hb_lamp    (hb_lamp)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_people_count <= 16'(count);
            r_occupied     <= count != '0;
            r_entry        <= entry_lamp;
            r_exit         <= exit_lamp;
            r_hb           <= hb_lamp;
            r_phase1       <= phase1;
            r_phase2       <= phase2;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_people_count   = r_people_count;
    assign o_occupied_lamp  = r_occupied;
    assign o_entry_lamp     = r_entry;
    assign o_exit_lamp      = r_exit;
    assign o_heartbeat_lamp = r_hb;
    assign o_door1_phase    = r_phase1;
    assign o_door2_phase    = r_phase2;

endmodule

`default_nettype wire

// ----- src/tdoc_door_lane.sv -----
// ----------------------------------------------------------------------------
// tdoc_door_lane
// Entry/exit sequence machine for one door with its timeout timer.
// ----------------------------------------------------------------------------
`default_nettype none

module tdoc_door_lane #(
    parameter int TIMER_BITS = tdoc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_clear,
    input  wire logic                        i_outer,
    input  wire logic                        i_inner,
    input  wire logic [tdoc_pkg::CFG_W-1:0]  i_timeout,
    output tdoc_pkg::t_door_evt              o_evt,
    output logic [1:0]                       o_phase
);

    localparam int CMP_W = (TIMER_BITS > tdoc_pkg::CFG_W) ? TIMER_BITS : tdoc_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    tdoc_pkg::t_door_mode r_mode, n_mode, cur_mode;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed, cur_el, inc_el;
    logic                  timed_out;

    // Apply a pending clear before the machine runs
    always_comb begin
        cur_mode  = i_clear ? tdoc_pkg::DOOR_FREE : r_mode;
        cur_el    = i_clear ? '0 : r_elapsed;
        inc_el    = (cur_el == TMAX) ? cur_el : cur_el + 1'b1;
        timed_out = CMP_W'(inc_el) > CMP_W'(i_timeout);
    end

    // Next state and timer
    always_comb begin
        n_mode    = cur_mode;
        n_elapsed = cur_el;
        case (cur_mode)
            tdoc_pkg::DOOR_FREE: begin
                if (i_outer && !i_inner) begin
                    n_mode    = tdoc_pkg::DOOR_MAYBE_IN;
                    n_elapsed = '0;
                end else if (i_inner && !i_outer) begin
                    n_mode    = tdoc_pkg::DOOR_MAYBE_OUT;
                    n_elapsed = '0;
                end
            end
            tdoc_pkg::DOOR_MAYBE_IN: begin
                n_elapsed = inc_el;
                if (i_inner) begin
                    n_mode    = tdoc_pkg::DOOR_BLOCKED;
                    n_elapsed = '0;
                end else if (timed_out) begin
                    n_mode    = tdoc_pkg::DOOR_FREE;
                    n_elapsed = '0;
                end
            end
            tdoc_pkg::DOOR_MAYBE_OUT: begin
                n_elapsed = inc_el;
                if (i_outer) begin
                    n_mode    = tdoc_pkg::DOOR_BLOCKED;
                    n_elapsed = '0;
                end else if (timed_out) begin
                    n_mode    = tdoc_pkg::DOOR_FREE;
                    n_elapsed = '0;
                end
            end
            tdoc_pkg::DOOR_BLOCKED: begin
                if (!i_outer && !i_inner) begin
                    n_mode = tdoc_pkg::DOOR_FREE;
                end
            end
            default: begin
                n_mode = tdoc_pkg::DOOR_FREE;
            end
        endcase
    end

    // Report confirmed events
    always_comb begin
        o_evt = '0;
        case (cur_mode)
            tdoc_pkg::DOOR_MAYBE_IN:  o_evt.entry = i_inner;
            tdoc_pkg::DOOR_MAYBE_OUT: o_evt.leave = i_outer;
            default:                  o_evt = '0;
        endcase
    end

    assign o_phase = n_mode;

    // Advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tdoc_pkg::DOOR_FREE;
            r_elapsed <= '0;
        end else if (i_adv) begin
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

`default_nettype wire

// ----- src/tdoc_merge.sv -----
// ----------------------------------------------------------------------------
// tdoc_merge
// Combines door events into the count; runs heartbeat, lamp pulses and the
// debounced clear button.
// ----------------------------------------------------------------------------
`default_nettype none

module tdoc_merge #(
    parameter int COUNT_BITS = tdoc_pkg::COUNT_BITS_DEF,
    parameter int TIMER_BITS = tdoc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_adv,
    input  wire tdoc_pkg::t_cfg          i_cfg,
    input  wire logic                    i_button,
    input  wire tdoc_pkg::t_door_evt     i_evt1,
    input  wire tdoc_pkg::t_door_evt     i_evt2,
    output logic                         o_clear,
    output logic [COUNT_BITS-1:0]        o_count,
    output logic                         o_entry_lamp,
    output logic                         o_exit_lamp,
    output logic                         o_hb_lamp
);

    localparam int CMP_W = (TIMER_BITS > tdoc_pkg::CFG_W) ? TIMER_BITS : tdoc_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_occ, n_occ, occ_clr, occ_d1;
    logic [TIMER_BITS-1:0] r_hb_el, n_hb_el, hb_inc;
    logic                  r_hb, n_hb;
    logic [TIMER_BITS-1:0] r_ent_left, n_ent_left, r_ext_left, n_ext_left, pulse_load;
    logic [TIMER_BITS-1:0] r_held, n_held;
    logic                  r_latched, n_latched;

    function automatic logic [COUNT_BITS-1:0] occ_step(
        input logic [COUNT_BITS-1:0] occ,
        input tdoc_pkg::t_door_evt   evt
    );
        logic [COUNT_BITS-1:0] res;
        res = occ;
        if (evt.entry && occ != CMAX) begin
            res = occ + 1'b1;
        end else if (evt.leave && occ != '0) begin
            res = occ - 1'b1;
        end
        return res;
    endfunction

    // Heartbeat toggle
    always_comb begin
        hb_inc  = (r_hb_el == TMAX) ? r_hb_el : r_hb_el + 1'b1;
        n_hb_el = hb_inc;
        n_hb    = r_hb;
        if (CMP_W'(hb_inc) >= CMP_W'(i_cfg.hb_half)) begin
            n_hb    = !r_hb;
            n_hb_el = '0;
        end
    end

    // Debounced one-shot clear
    always_comb begin
        n_held    = r_held;
        n_latched = r_latched;
        o_clear   = 1'b0;
        if (i_button) begin
            if (CMP_W'(r_held) < CMP_W'(i_cfg.debounce)) begin
                n_held = (r_held == TMAX) ? r_held : r_held + 1'b1;
            end else if (!r_latched) begin
                o_clear   = 1'b1;
                n_latched = 1'b1;
            end
        end else begin
            n_held    = '0;
            n_latched = 1'b0;
        end
    end

    // Merge door events in door order
    always_comb begin
        occ_clr = o_clear ? '0 : r_occ;
        occ_d1  = occ_step(occ_clr, i_evt1);
        n_occ   = occ_step(occ_d1, i_evt2);
    end

    // Count down lamp pulses, reload on an event
    always_comb begin
        pulse_load = (CMP_W'(i_cfg.pulse_len) > CMP_W'(TMAX)) ? TMAX
                                                              : TIMER_BITS'(i_cfg.pulse_len);
        n_ent_left = (r_ent_left != '0) ? r_ent_left - 1'b1 : r_ent_left;
        n_ext_left = (r_ext_left != '0) ? r_ext_left - 1'b1 : r_ext_left;
        if (i_evt1.entry || i_evt2.entry) begin
            n_ent_left = pulse_load;
        end
        if (i_evt1.leave || i_evt2.leave) begin
            n_ext_left = pulse_load;
        end
    end

    assign o_count      = n_occ;
    assign o_entry_lamp = n_ent_left != '0;
    assign o_exit_lamp  = n_ext_left != '0;
    assign o_hb_lamp    = n_hb;

    // Advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_hb_el    <= '0;
            r_hb       <= 1'b0;
            r_ent_left <= '0;
            r_ext_left <= '0;
            r_held     <= '0;
            r_latched  <= 1'b0;
        end else if (i_adv) begin
            r_occ      <= n_occ;
            r_hb_el    <= n_hb_el;
            r_hb       <= n_hb;
            r_ent_left <= n_ent_left;
            r_ext_left <= n_ext_left;
            r_held     <= n_held;
            r_latched  <= n_latched;
        end
    end

endmodule

`default_nettype wire
